>>> src/wis_pkg.sv
// Shared types and constants for the weighted interval scheduler.
`default_nettype none
package wis_pkg;

  // Fixed widths of the item fields on the ports.
  localparam int unsigned FieldTimeBits  = 16;
  localparam int unsigned FieldTotalBits = 21;

  // One input item as it arrives on the push side.
  typedef struct packed {
    logic [FieldTimeBits-1:0] start_time;
    logic [FieldTimeBits-1:0] finish_time;
    logic                     last_interval;
  } wis_in_t;

  // One result item as it leaves on the pop side.
  typedef struct packed {
    logic [FieldTimeBits-1:0]  chosen_start;
    logic [FieldTimeBits-1:0]  chosen_finish;
    logic [FieldTotalBits-1:0] total_duration;
    logic                      has_interval;
    logic                      dropped_input;
    logic                      last_result;
  } wis_out_t;

  // Classified interval handed from the front part to the back part.
  typedef struct packed {
    logic [FieldTimeBits-1:0] start_time;
    logic [FieldTimeBits-1:0] finish_time;
    logic                     keep;
    logic                     last;
  } wis_cmd_t;

endpackage : wis_pkg
`default_nettype wire

>>> src/wis_fifo.sv
// Small first-in first-out queue of fixed-width words.
`default_nettype none
module wis_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage words need no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule : wis_fifo
`default_nettype wire

>>> src/wis_front.sv
// Front part: accepts intervals and marks those that exceed capacity.
`default_nettype none
module wis_front #(
  parameter int unsigned MAX_INTERVALS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire wis_pkg::wis_in_t  item_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output wis_pkg::wis_cmd_t      q_cmd_o
);
  import wis_pkg::*;

  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          keep;

  assign q_push_o = push_i && !q_full_i;
  assign keep     = (cnt_q != CW'(MAX_INTERVALS));

  always_comb begin
    q_cmd_o.start_time  = item_i.start_time;
    q_cmd_o.finish_time = item_i.finish_time;
    q_cmd_o.keep        = keep;
    q_cmd_o.last        = item_i.last_interval;
  end

  // Count stored intervals of the current set; the last one closes the set.
  always_comb begin
    cnt_d = cnt_q;
    if (q_push_o) begin
      if (item_i.last_interval) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule : wis_front
`default_nettype wire

>>> src/wis_back.sv
// Back part: stores a set, sorts it, runs the dynamic program and traces back.
`default_nettype none
module wis_back #(
  parameter int unsigned MAX_INTERVALS = 32,
  parameter int unsigned TIME_BITS     = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire wis_pkg::wis_cmd_t q_cmd_i,
  output logic                   q_pop_o,
  input  wire logic              res_full_i,
  output logic                   res_push_o,
  output wis_pkg::wis_out_t      res_o
);
  import wis_pkg::*;

  localparam int unsigned IW = $clog2(MAX_INTERVALS);
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned BW = TIME_BITS + CW;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_RLOAD = 3'd1;
  localparam logic [2:0] S_RANK  = 3'd2;
  localparam logic [2:0] S_PLOAD = 3'd3;
  localparam logic [2:0] S_PRED  = 3'd4;
  localparam logic [2:0] S_DP    = 3'd5;
  localparam logic [2:0] S_TRACE = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  // Register files: raw, sorted, predecessor, best totals, pick stack.
  logic [TIME_BITS-1:0] st_q [MAX_INTERVALS];
  logic [TIME_BITS-1:0] fn_q [MAX_INTERVALS];
  logic [TIME_BITS-1:0] ss_q [MAX_INTERVALS];
  logic [TIME_BITS-1:0] sf_q [MAX_INTERVALS];
  logic [CW-1:0]        pred_q [MAX_INTERVALS];
  logic [BW-1:0]        best_q [MAX_INTERVALS];
  logic [IW-1:0]        stack_q [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] take_q;

  logic [2:0]           state_q;
  logic [CW-1:0]        cnt_q, rank_q, p_q, tp_q, sp_q;
  logic [IW-1:0]        i_q, j_q;
  logic                 ovf_q;
  logic [TIME_BITS-1:0] hs_q, hf_q;
  logic [BW-1:0]        prev_q, total_q;

  // Read ports.
  logic [IW-1:0]        st_addr, ss_addr, sf_addr, pred_addr, top_idx;
  logic [TIME_BITS-1:0] st_rd, fn_rd, ss_rd, sf_rd;
  logic [CW-1:0]        pred_rd;
  logic [BW-1:0]        best_rd;

  // Step logic.
  logic                 i_end, j_end, inc, below;
  logic [CW-1:0]        rank_fin, p_new, sp_dec;
  logic [TIME_BITS-1:0] dur;
  logic [BW-1:0]        bp, with_v, best_v;
  logic                 take_v;

  assign i_end  = (CW'(i_q) == cnt_q - 1'b1);
  assign j_end  = (CW'(j_q) == cnt_q - 1'b1);
  assign sp_dec = sp_q - 1'b1;
  assign top_idx = stack_q[sp_dec[IW-1:0]];

  always_comb begin
    st_addr = (state_q == S_RLOAD) ? i_q : j_q;
    case (state_q)
      S_EMIT:  ss_addr = top_idx;
      default: ss_addr = i_q;
    endcase
    case (state_q)
      S_PRED:  sf_addr = j_q;
      S_EMIT:  sf_addr = top_idx;
      default: sf_addr = i_q;
    endcase
    pred_addr = (state_q == S_TRACE) ? IW'(tp_q - 1'b1) : i_q;
  end

  assign st_rd   = st_q[st_addr];
  assign fn_rd   = fn_q[st_addr];
  assign ss_rd   = ss_q[ss_addr];
  assign sf_rd   = sf_q[sf_addr];
  assign pred_rd = pred_q[pred_addr];
  assign best_rd = best_q[IW'(pred_rd - 1'b1)];

  // Rank compare: earlier finish, equal finish with a larger start, or an equal pair loaded earlier.
  always_comb begin
    inc = (fn_rd < hf_q) || ((fn_rd == hf_q) && (st_rd > hs_q)) ||
          ((fn_rd == hf_q) && (st_rd == hs_q) && (j_q < i_q));
    rank_fin = rank_q + CW'(inc);
  end

  // Predecessor compare against the held start.
  assign below = (sf_rd <= hs_q);
  assign p_new = below ? CW'(j_q) + 1'b1 : p_q;

  // Dynamic program step; a reversed interval has no duration.
  always_comb begin
    dur    = (sf_rd < ss_rd) ? '0 : sf_rd - ss_rd;
    bp     = (pred_rd != '0) ? best_rd : '0;
    with_v = BW'(dur) + bp;
    take_v = (with_v > prev_q);
    best_v = take_v ? with_v : prev_q;
  end

  assign q_pop_o = (state_q == S_LOAD) && !q_empty_i;

  // Result formation, both for chosen intervals and the empty selection.
  always_comb begin
    res_push_o = 1'b0;
    res_o      = '0;
    if (state_q == S_EMIT && !res_full_i) begin
      res_push_o = 1'b1;
      if (sp_q != '0) begin
        res_o.chosen_start   = FieldTimeBits'(ss_rd);
        res_o.chosen_finish  = FieldTimeBits'(sf_rd);
        res_o.total_duration = FieldTotalBits'(total_q);
        res_o.has_interval   = 1'b1;
      end
      res_o.dropped_input = ovf_q;
      res_o.last_result   = (sp_q <= CW'(1));
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      rank_q  <= '0;
      p_q     <= '0;
      tp_q    <= '0;
      sp_q    <= '0;
      prev_q  <= '0;
      total_q <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (q_pop_o) begin
            if (q_cmd_i.keep) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (q_cmd_i.last) begin
              i_q     <= '0;
              state_q <= S_RLOAD;
            end
          end
        end
        S_RLOAD: begin
          j_q     <= '0;
          rank_q  <= '0;
          state_q <= S_RANK;
        end
        S_RANK: begin
          if (j_end) begin
            if (i_end) begin
              i_q     <= '0;
              state_q <= S_PLOAD;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_RLOAD;
            end
          end else begin
            j_q    <= j_q + 1'b1;
            rank_q <= rank_fin;
          end
        end
        S_PLOAD: begin
          j_q <= '0;
          p_q <= '0;
          if (i_q == '0) begin
            if (i_end) begin
              prev_q  <= '0;
              state_q <= S_DP;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            state_q <= S_PRED;
          end
        end
        S_PRED: begin
          if (j_q == i_q - 1'b1) begin
            if (i_end) begin
              i_q     <= '0;
              prev_q  <= '0;
              state_q <= S_DP;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_PLOAD;
            end
          end else begin
            j_q <= j_q + 1'b1;
            p_q <= p_new;
          end
        end
        S_DP: begin
          prev_q <= best_v;
          if (i_end) begin
            total_q <= best_v;
            tp_q    <= cnt_q;
            sp_q    <= '0;
            state_q <= S_TRACE;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_TRACE: begin
          if (tp_q == '0) begin
            state_q <= S_EMIT;
          end else if (take_q[pred_addr]) begin
            sp_q <= sp_q + 1'b1;
            tp_q <= pred_rd;
          end else begin
            tp_q <= tp_q - 1'b1;
          end
        end
        S_EMIT: begin
          if (res_push_o) begin
            if (sp_q <= CW'(1)) begin
              sp_q    <= '0;
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              sp_q <= sp_dec;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Register file writes; entries are only read once written in this set.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && q_pop_o && q_cmd_i.keep) begin
      st_q[cnt_q[IW-1:0]] <= TIME_BITS'(q_cmd_i.start_time);
      fn_q[cnt_q[IW-1:0]] <= TIME_BITS'(q_cmd_i.finish_time);
    end
    if (state_q == S_RLOAD) begin
      hs_q <= st_rd;
      hf_q <= fn_rd;
    end
    if (state_q == S_PLOAD) begin
      hs_q <= ss_rd;
    end
    if (state_q == S_RANK && j_end) begin
      ss_q[rank_fin[IW-1:0]] <= hs_q;
      sf_q[rank_fin[IW-1:0]] <= hf_q;
    end
    if (state_q == S_PLOAD && i_q == '0) begin
      pred_q[0] <= '0;
    end
    if (state_q == S_PRED && j_q == i_q - 1'b1) begin
      pred_q[i_q] <= p_new;
    end
    if (state_q == S_DP) begin
      best_q[i_q] <= best_v;
      take_q[i_q] <= take_v;
    end
    if (state_q == S_TRACE && tp_q != '0 && take_q[pred_addr]) begin
      stack_q[sp_q[IW-1:0]] <= pred_addr;
    end
  end

  // Results only leave during the emit phase.
  a_push_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (state_q == S_EMIT))
    else $error("result pushed outside the emit phase");

  // The pick stack never holds more entries than the set.
  a_stack_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRACE) |-> (sp_q <= cnt_q))
    else $error("pick stack overran the stored set");

  // The final result of a run hands control back to loading.
  a_last_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last_result) |=> (state_q == S_LOAD && cnt_q == '0))
    else $error("run did not return to loading after its final result");

  // No input transfer is taken while a set is being worked on.
  a_no_pop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> !q_pop_o)
    else $error("input transfer taken during a run");

endmodule : wis_back
`default_nettype wire

>>> src/weighted_interval_scheduler.sv
// Top level of the weighted interval scheduler.
// Intervals are pushed into a short queue one per cycle while it is not full,
// and are stored until one marked last arrives; intervals beyond
// MAX_INTERVALS are dropped and flagged. The set of stored intervals is
// then ranked by finish time, predecessors are searched, the dynamic program
// runs and the traceback follows; each chosen interval then leaves through
// the result queue one per cycle while that queue is not full. New
// intervals queue up in front while a run is in progress.
`default_nettype none
module weighted_interval_scheduler #(
  parameter int unsigned MAX_INTERVALS = 32,
  parameter int unsigned TIME_BITS     = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  input  wire wis_pkg::wis_in_t in_item_i,
  output logic                  full,
  output logic                  empty,
  input  wire logic             pop,
  output wis_pkg::wis_out_t     out_item_o
);
  import wis_pkg::*;

  logic     cq_push, cq_full, cq_pop, cq_empty, rq_push, rq_full;
  wis_cmd_t cq_wdata, cq_rdata;
  wis_out_t rq_wdata;

  assign full = cq_full;

  wis_front #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .q_full_i(cq_full),
    .q_push_o(cq_push),
    .q_cmd_o (cq_wdata)
  );

  // Queue between the front and back parts.
  wis_fifo #(
    .WIDTH($bits(wis_cmd_t)),
    .DEPTH(4)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cq_push),
    .wdata_i(cq_wdata),
    .full_o (cq_full),
    .pop_i  (cq_pop),
    .rdata_o(cq_rdata),
    .empty_o(cq_empty)
  );

  wis_back #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .TIME_BITS    (TIME_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (cq_empty),
    .q_cmd_i   (cq_rdata),
    .q_pop_o   (cq_pop),
    .res_full_i(rq_full),
    .res_push_o(rq_push),
    .res_o     (rq_wdata)
  );

  // Result queue towards the pop side.
  wis_fifo #(
    .WIDTH($bits(wis_out_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rq_push),
    .wdata_i(rq_wdata),
    .full_o (rq_full),
    .pop_i  (pop),
    .rdata_o(out_item_o),
    .empty_o(empty)
  );

endmodule : weighted_interval_scheduler
`default_nettype wire

>>> tb/weighted_interval_scheduler_test.sv
// Self-checking testbench for the weighted interval scheduler.
`timescale 1ns / 100ps
`default_nettype none
module weighted_interval_scheduler_test;
  import wis_pkg::*;

  localparam int unsigned Capacity   = 32;
  localparam int unsigned WatchLimit = 200000;

  // Predicts the chosen intervals of each set and checks the results against them.
  class selection_board;
    logic [15:0] starts[$];
    logic [15:0] finishes[$];
    bit          overflowed;
    wis_out_t    pending[$];
    int          errors;

    function void note_interval(wis_in_t item);
      if (starts.size() < Capacity) begin
        starts.push_back(item.start_time);
        finishes.push_back(item.finish_time);
      end else begin
        overflowed = 1'b1;
      end
      if (item.last_interval) begin
        solve_set();
        starts.delete();
        finishes.delete();
        overflowed = 1'b0;
      end
    endfunction

    function void solve_set();
      int           n;
      int           ord[Capacity];
      int           pred[Capacity];
      longint       best[Capacity];
      int           picked[$];
      int           i;
      int           j;
      int           v;
      longint       dur;
      longint       without;
      longint       with_it;
      wis_out_t     res;
      n = starts.size();
      // Insertion sort by finish ascending, larger start first on ties.
      for (i = 0; i < n; i++) begin
        v = i;
        j = i;
        while (j > 0 && (finishes[v] < finishes[ord[j-1]] ||
               (finishes[v] == finishes[ord[j-1]] && starts[v] > starts[ord[j-1]]))) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = v;
      end
      // Last compatible earlier interval, stored as one plus its position.
      for (i = 0; i < n; i++) begin
        pred[i] = 0;
        for (j = 0; j < i; j++)
          if (finishes[ord[j]] <= starts[ord[i]]) pred[i] = j + 1;
      end
      for (i = 0; i < n; i++) begin
        without = (i > 0) ? best[i-1] : 0;
        dur = (finishes[ord[i]] < starts[ord[i]]) ? 0 :
              longint'(finishes[ord[i]]) - longint'(starts[ord[i]]);
        with_it = dur + ((pred[i] != 0) ? best[pred[i]-1] : 0);
        best[i] = (with_it > without) ? with_it : without;
      end
      // Walk back from the end; an interval is taken only on a strict gain.
      i = n;
      while (i > 0) begin
        without = (i > 1) ? best[i-2] : 0;
        if (best[i-1] > without) begin
          picked.push_front(i - 1);
          i = pred[i-1];
        end else begin
          i = i - 1;
        end
      end
      res = '0;
      res.dropped_input = overflowed;
      if (picked.size() == 0) begin
        res.last_result = 1'b1;
        pending.push_back(res);
      end else begin
        foreach (picked[k]) begin
          res.chosen_start   = starts[ord[picked[k]]];
          res.chosen_finish  = finishes[ord[picked[k]]];
          res.total_duration = best[n-1][20:0];
          res.has_interval   = 1'b1;
          res.last_result    = (k == picked.size() - 1);
          pending.push_back(res);
        end
      end
    endfunction

    function void check_result(wis_out_t got);
      wis_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.chosen_start !== want.chosen_start) begin
        $display("%0t: chosen_start expected %h actual %h", $time,
                 want.chosen_start, got.chosen_start);
        errors++;
      end
      if (got.chosen_finish !== want.chosen_finish) begin
        $display("%0t: chosen_finish expected %h actual %h", $time,
                 want.chosen_finish, got.chosen_finish);
        errors++;
      end
      if (got.total_duration !== want.total_duration) begin
        $display("%0t: total_duration expected %h actual %h", $time,
                 want.total_duration, got.total_duration);
        errors++;
      end
      if (got.has_interval !== want.has_interval) begin
        $display("%0t: has_interval expected %b actual %b", $time,
                 want.has_interval, got.has_interval);
        errors++;
      end
      if (got.dropped_input !== want.dropped_input) begin
        $display("%0t: dropped_input expected %b actual %b", $time,
                 want.dropped_input, got.dropped_input);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $display("%0t: last_result expected %b actual %b", $time,
                 want.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  wis_in_t  in_item_i = '0;
  logic     full;
  logic     empty;
  wis_out_t out_item_o;

  selection_board board = new();
  int  send_idle_pct = 0;
  int  pop_stall_pct = 0;
  int  quiet_cycles = 0;

  weighted_interval_scheduler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: stalls at random and checks every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) board.check_result(out_item_o);
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Presents one interval and holds it until the transfer happens. Push stays
  // high afterwards so that items can follow back to back; idling or draining
  // lowers it.
  task automatic send_interval(logic [15:0] st, logic [15:0] fin, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= '{start_time: st, finish_time: fin, last_interval: last};
    do @(posedge clk_i); while (full);
    board.note_interval(in_item_i);
  endtask

  // A set of random intervals; most last up to span, some get a random finish that may lie before the start.
  task automatic send_random_set(int count, int span);
    logic [15:0] st;
    for (int i = 0; i < count; i++) begin
      st = 16'($urandom_range(65535));
      if ($urandom_range(9) == 0)
        send_interval(st, 16'($urandom_range(65535)), i == count - 1);
      else
        send_interval(st, 16'(st + $urandom_range(span)), i == count - 1);
    end
  endtask

  // Stops sending and waits until every expected result has come.
  task automatic drain_results();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  int count;

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: lone interval, field extremes, reversed, empty selection, ties.
    send_interval(16'h0000, 16'hFFFF, 1'b1);
    send_interval(16'hFFFF, 16'h0000, 1'b1);
    send_interval(16'h1234, 16'h1234, 1'b1);
    send_interval(16'd10, 16'd20, 1'b0);
    send_interval(16'd15, 16'd20, 1'b0);
    send_interval(16'd20, 16'd30, 1'b0);
    send_interval(16'd0, 16'd25, 1'b1);
    send_interval(16'h5555, 16'hAAAA, 1'b0);
    send_interval(16'hAAAA, 16'hFFFF, 1'b1);
    drain_results();
    // Capacity exceeded, with the marked last one dropped too.
    send_random_set(Capacity + 2, 3000);
    drain_results();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 59; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 59; end
        default: begin send_idle_pct = 35; pop_stall_pct = 35; end
      endcase
      for (int s = 0; s < 80; s += count) begin
        count = ($urandom_range(7) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
        send_random_set(count, ($urandom_range(1) == 1) ? 200 : 65535);
      end
      drain_results();
    end
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
